// ----- rtl/scsu_pkg.sv -----
// Shared operation codes, field codes and the control struct of the shift/saturate pipeline.
package scsu_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_IMM_SHIFT = 2'd0;
    localparam logic [1:0] CMD_REG_SHIFT = 2'd1;
    localparam logic [1:0] CMD_SSAT      = 2'd2;
    localparam logic [1:0] CMD_USAT      = 2'd3;

    // Shift type codes
    localparam logic [1:0] KIND_LSL = 2'd0;
    localparam logic [1:0] KIND_LSR = 2'd1;
    localparam logic [1:0] KIND_ASR = 2'd2;
    localparam logic [1:0] KIND_ROR = 2'd3;

    // Width of the shift amount field
    localparam int AMT_BITS = 8;

    typedef logic [2:0] t_op;

    // Decoded operation carried down the pipeline
    localparam t_op OP_PASS = 3'd0;
    localparam t_op OP_LSL  = 3'd1;
    localparam t_op OP_LSR  = 3'd2;
    localparam t_op OP_ASR  = 3'd3;
    localparam t_op OP_ROR  = 3'd4;
    localparam t_op OP_RRX  = 3'd5;
    localparam t_op OP_SSAT = 3'd6;
    localparam t_op OP_USAT = 3'd7;

    typedef struct packed {
        t_op  op;
        logic carry;
    } t_ctl;

    function automatic t_op kind_op(input logic [1:0] kind);
        t_op op;
        case (kind)
            KIND_LSL: op = OP_LSL;
            KIND_LSR: op = OP_LSR;
            KIND_ASR: op = OP_ASR;
            KIND_ROR: op = OP_ROR;
            default:  op = OP_PASS;
        endcase
        return op;
    endfunction

endpackage

// ----- rtl/scsu_decode.sv -----
// First stage: decode command, shift type and amount, and clamp the saturation width.
module scsu_decode
    import scsu_pkg::*;
#(
    parameter int DATA_BITS = 32,
    parameter int KW        = $clog2(DATA_BITS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_command,
    input  logic [DATA_BITS-1:0] i_value,
    input  logic [1:0]           i_shift_kind,
    input  logic [AMT_BITS-1:0]  i_shift_amount,
    input  logic                 i_carry_in,
    input  logic [5:0]           i_sat_width,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_ctl                 o_ctl,
    output logic [DATA_BITS-1:0] o_value,
    output logic [AMT_BITS-1:0]  o_amount,
    output logic [KW-1:0]        o_sat_sh
);

    localparam logic [AMT_BITS-1:0] FULL_AMT = AMT_BITS'(DATA_BITS);
    localparam logic [6:0]          W_MAX    = 7'(DATA_BITS);

    logic                 r_valid;
    t_ctl                 r_ctl;
    logic [DATA_BITS-1:0] r_value;
    logic [AMT_BITS-1:0]  r_amount;
    logic [KW-1:0]        r_sat_sh;

    t_op                 n_op;
    logic [AMT_BITS-1:0] n_amount;
    logic [KW-1:0]       n_sat_sh;
    logic [4:0]          imm5;
    logic [6:0]          w_ext;
    logic [6:0]          w_clamp;

    assign o_stall = r_valid && i_stall;

    always_comb begin
        imm5     = i_shift_amount[4:0];
        w_ext    = {1'b0, i_sat_width};
        w_clamp  = (w_ext > W_MAX) ? W_MAX : w_ext;
        n_op     = OP_PASS;
        n_amount = i_shift_amount;
        n_sat_sh = '0;
        case (i_command)
            CMD_IMM_SHIFT: begin
                n_amount = {3'b000, imm5};
                if (imm5 == 5'd0) begin
                    case (i_shift_kind)
                        KIND_LSL: n_op = OP_PASS;
                        KIND_LSR: begin
                            n_op     = OP_LSR;
                            n_amount = FULL_AMT;
                        end
                        KIND_ASR: begin
                            n_op     = OP_ASR;
                            n_amount = FULL_AMT;
                        end
                        KIND_ROR: n_op = OP_RRX;
                        default:  n_op = OP_PASS;
                    endcase
                end else begin
                    n_op = kind_op(i_shift_kind);
                end
            end
            CMD_REG_SHIFT: begin
                n_op = (i_shift_amount == '0) ? OP_PASS : kind_op(i_shift_kind);
            end
            CMD_SSAT: begin
                n_op     = OP_SSAT;
                // width zero acts as one: the clamp point sits at bit 0
                n_sat_sh = (w_clamp == 7'd0) ? '0 : KW'(w_clamp - 7'd1);
            end
            CMD_USAT: begin
                n_op     = OP_USAT;
                n_sat_sh = KW'(w_clamp);
            end
            default: n_op = OP_PASS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ctl.op    <= n_op;
            r_ctl.carry <= i_carry_in;
            r_value     <= i_value;
            r_amount    <= n_amount;
            r_sat_sh    <= n_sat_sh;
        end
    end

    assign o_valid  = r_valid;
    assign o_ctl    = r_ctl;
    assign o_value  = r_value;
    assign o_amount = r_amount;
    assign o_sat_sh = r_sat_sh;

endmodule

// ----- rtl/scsu_exec.sv -----
// Second stage: barrel shift, rotate and carry, or saturation range test and limit mask.
module scsu_exec
    import scsu_pkg::*;
#(
    parameter int DATA_BITS = 32,
    parameter int KW        = $clog2(DATA_BITS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_ctl                 i_ctl,
    input  logic [DATA_BITS-1:0] i_value,
    input  logic [AMT_BITS-1:0]  i_amount,
    input  logic [KW-1:0]        i_sat_sh,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_ctl                 o_ctl,
    output logic [DATA_BITS-1:0] o_res,
    output logic                 o_over,
    output logic [DATA_BITS-1:0] o_mask
);

    localparam logic [DATA_BITS-1:0] ONES = '1;

    logic                 r_valid;
    t_ctl                 r_ctl;
    logic [DATA_BITS-1:0] r_res;
    logic                 r_over;
    logic [DATA_BITS-1:0] r_mask;

    logic [DATA_BITS-1:0] rot_lvl [AMT_BITS+1];
    logic [DATA_BITS:0]   ext_l;
    logic [DATA_BITS:0]   ext_r;
    logic [DATA_BITS:0]   ext_a;
    logic [DATA_BITS-1:0] sat_t;
    logic [DATA_BITS-1:0] n_res;
    logic                 n_carry;
    logic                 n_over;

    // Rotate by the amount modulo the width: each amount bit rotates by a fixed step
    assign rot_lvl[0] = i_value;
    for (genvar g = 0; g < AMT_BITS; g++) begin : g_rot
        localparam int STEP = (2 ** g) % DATA_BITS;
        assign rot_lvl[g+1] = i_amount[g]
            ? ((rot_lvl[g] >> STEP) | (rot_lvl[g] << (DATA_BITS - STEP)))
            : rot_lvl[g];
    end

    // One guard bit beside the word catches the last bit shifted out
    assign ext_l = {1'b0, i_value} << i_amount;
    assign ext_r = {i_value, 1'b0} >> i_amount;
    assign ext_a = $unsigned($signed({i_value, 1'b0}) >>> i_amount);

    always_comb begin
        n_res   = i_value;
        n_carry = i_ctl.carry;
        n_over  = 1'b0;
        sat_t   = '0;
        case (i_ctl.op)
            OP_LSL: begin
                n_res   = ext_l[DATA_BITS-1:0];
                n_carry = ext_l[DATA_BITS];
            end
            OP_LSR: begin
                n_res   = ext_r[DATA_BITS:1];
                n_carry = ext_r[0];
            end
            OP_ASR: begin
                n_res   = ext_a[DATA_BITS:1];
                n_carry = ext_a[0];
            end
            OP_ROR: begin
                n_res   = rot_lvl[AMT_BITS];
                n_carry = rot_lvl[AMT_BITS][DATA_BITS-1];
            end
            OP_RRX: begin
                n_res   = {i_ctl.carry, i_value[DATA_BITS-1:1]};
                n_carry = i_value[0];
            end
            OP_SSAT: begin
                sat_t  = $unsigned($signed(i_value) >>> i_sat_sh);
                n_over = (sat_t != '0) && (sat_t != ONES);
            end
            OP_USAT: begin
                sat_t  = i_value >> i_sat_sh;
                n_over = (sat_t != '0);
            end
            default: begin
                n_res   = i_value;
                n_carry = i_ctl.carry;
            end
        endcase
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ctl.op    <= i_ctl.op;
            r_ctl.carry <= n_carry;
            r_res       <= n_res;
            r_over      <= n_over;
            r_mask      <= ~(ONES << i_sat_sh);
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_res   = r_res;
    assign o_over  = r_over;
    assign o_mask  = r_mask;

endmodule

// ----- rtl/scsu_final.sv -----
// Third stage: apply saturation limits, select the result and hold the output beat.
module scsu_final
    import scsu_pkg::*;
#(
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_ctl                 i_ctl,
    input  logic [DATA_BITS-1:0] i_res,
    input  logic                 i_over,
    input  logic [DATA_BITS-1:0] i_mask,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_BITS-1:0] o_result,
    output logic                 o_carry_out,
    output logic                 o_saturated
);

    logic                 r_valid;
    logic [DATA_BITS-1:0] r_result;
    logic                 r_carry;
    logic                 r_sat;

    logic [DATA_BITS-1:0] n_result;
    logic                 n_sat;
    logic                 sign;

    assign sign = i_res[DATA_BITS-1];

    always_comb begin
        n_result = i_res;
        n_sat    = 1'b0;
        case (i_ctl.op)
            OP_SSAT: begin
                if (i_over) begin
                    n_result = sign ? ~i_mask : i_mask;
                    n_sat    = 1'b1;
                end
            end
            OP_USAT: begin
                if (sign) begin
                    n_result = '0;
                    n_sat    = 1'b1;
                end else if (i_over) begin
                    n_result = i_mask;
                    n_sat    = 1'b1;
                end
            end
            default: begin
                n_result = i_res;
                n_sat    = 1'b0;
            end
        endcase
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_result <= n_result;
            r_carry  <= i_ctl.carry;
            r_sat    <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_result    = r_result;
    assign o_carry_out = r_carry;
    assign o_saturated = r_sat;

endmodule

// ----- rtl/shift_carry_and_saturate_unit.sv -----
// Top level of the shift, carry and saturate unit: three-stage execute datapath.
//
// Channels: an input beat (command, value, shift type, shift amount, carry in,
// saturation width) is taken on a rising edge with i_valid high and o_stall low;
// a result beat (result, carry out, saturated flag) is taken with o_valid high
// and i_stall low. Each input beat yields exactly one result beat, in order.
// An accepted beat passes the three register stages (decode, shift/test,
// select) in turn, each holding one beat; with i_stall low one beat per cycle
// goes through, and a new beat enters as the previous one moves on.
// Reset (i_rst_n low at a clock edge) empties all three stages; no state is
// kept between beats, so nothing else needs clearing.
// Stall: when the receiver holds i_stall, the output beat holds and stages
// behind it fill up as bubbles are squeezed out; o_stall rises once the first
// stage holds a beat that cannot move. No beat is dropped or repeated.
// Shift amounts follow the architecture: immediate LSR/ASR by zero mean the full
// width, immediate ROR by zero is RRX, register amounts above the width give
// zero or sign fill, and rotation wraps modulo the width.
module shift_carry_and_saturate_unit
    import scsu_pkg::*;
#(
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_command,
    input  logic [DATA_BITS-1:0] i_value,
    input  logic [1:0]           i_shift_kind,
    input  logic [7:0]           i_shift_amount,
    input  logic                 i_carry_in,
    input  logic [5:0]           i_sat_width,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_BITS-1:0] o_result,
    output logic                 o_carry_out,
    output logic                 o_saturated
);

    // Saturation shift count spans 0 to the full width
    localparam int KW = $clog2(DATA_BITS + 1);

    // Decode -> shift/test
    logic                 dec_valid;
    logic                 dec_stall;
    t_ctl                 dec_ctl;
    logic [DATA_BITS-1:0] dec_value;
    logic [AMT_BITS-1:0]  dec_amount;
    logic [KW-1:0]        dec_sat_sh;

    // Shift/test -> select
    logic                 exe_valid;
    logic                 exe_stall;
    t_ctl                 exe_ctl;
    logic [DATA_BITS-1:0] exe_res;
    logic                 exe_over;
    logic [DATA_BITS-1:0] exe_mask;

    scsu_decode #(
        .DATA_BITS (DATA_BITS),
        .KW        (KW)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_value        (i_value),
        .i_shift_kind   (i_shift_kind),
        .i_shift_amount (i_shift_amount),
        .i_carry_in     (i_carry_in),
        .i_sat_width    (i_sat_width),
        .o_valid        (dec_valid),
        .i_stall        (dec_stall),
        .o_ctl          (dec_ctl),
        .o_value        (dec_value),
        .o_amount       (dec_amount),
        .o_sat_sh       (dec_sat_sh)
    );

    // Shifts, rotate and carry, or the saturation range test
    scsu_exec #(
        .DATA_BITS (DATA_BITS),
        .KW        (KW)
    ) u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dec_valid),
        .o_stall  (dec_stall),
        .i_ctl    (dec_ctl),
        .i_value  (dec_value),
        .i_amount (dec_amount),
        .i_sat_sh (dec_sat_sh),
        .o_valid  (exe_valid),
        .i_stall  (exe_stall),
        .o_ctl    (exe_ctl),
        .o_res    (exe_res),
        .o_over   (exe_over),
        .o_mask   (exe_mask)
    );

    // Clamp, select and hold the output beat
    scsu_final #(
        .DATA_BITS (DATA_BITS)
    ) u_final (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (exe_valid),
        .o_stall     (exe_stall),
        .i_ctl       (exe_ctl),
        .i_res       (exe_res),
        .i_over      (exe_over),
        .i_mask      (exe_mask),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .o_carry_out (o_carry_out),
        .o_saturated (o_saturated)
    );

endmodule

// ----- tb/sv/scsu_result_checker.sv -----
// Checker for the shift, carry and saturate unit: predicts each result beat and compares it.
`timescale 1ns / 100ps
module scsu_result_checker
    import scsu_pkg::*;
#(
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  logic                 i_cmd_stall,
    input  logic [1:0]           i_command,
    input  logic [DATA_BITS-1:0] i_value,
    input  logic [1:0]           i_shift_kind,
    input  logic [7:0]           i_shift_amount,
    input  logic                 i_carry_in,
    input  logic [5:0]           i_sat_width,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic [DATA_BITS-1:0] i_result,
    input  logic                 i_carry_out,
    input  logic                 i_saturated,
    output int                   o_mismatch_count,
    output int                   o_outstanding
);

    localparam int W = DATA_BITS;

    typedef struct packed {
        logic [W-1:0] result;
        logic         carry;
        logic         saturated;
    } t_shift_sat;

    t_shift_sat pending_results[$];
    int         mismatch_count = 0;

    // Shift of kind by n, n at least one; n may exceed the width.
    function automatic t_shift_sat shift_by(input logic [1:0] kind, input logic [W-1:0] x,
                                            input int unsigned n);
        t_shift_sat        r;
        logic [W:0]        wide;
        logic signed [W:0] swide;
        int unsigned       m;
        r.saturated = 1'b0;
        r.result    = '0;
        r.carry     = 1'b0;
        case (kind)
            KIND_LSL: begin
                if (n <= W) begin
                    wide     = {1'b0, x} << n;
                    r.result = wide[W-1:0];
                    r.carry  = wide[W];
                end
            end
            KIND_LSR: begin
                if (n <= W) begin
                    wide     = {x, 1'b0} >> n;
                    r.result = wide[W:1];
                    r.carry  = wide[0];
                end
            end
            KIND_ASR: begin
                if (n >= W) begin
                    r.result = {W{x[W-1]}};
                    r.carry  = x[W-1];
                end else begin
                    swide    = {x, 1'b0};
                    swide    = swide >>> n;
                    r.result = swide[W:1];
                    r.carry  = swide[0];
                end
            end
            default: begin
                m        = n % W;
                r.result = (m == 0) ? x : ((x >> m) | (x << (W - m)));
                r.carry  = r.result[W-1];
            end
        endcase
        return r;
    endfunction

    function automatic t_shift_sat predict_shift_sat(input logic [1:0] cmd,
                                                     input logic [W-1:0] value,
                                                     input logic [1:0] kind,
                                                     input logic [7:0] amount,
                                                     input logic cin,
                                                     input logic [5:0] width);
        t_shift_sat  r;
        int unsigned w;
        longint      v;
        longint      hi;
        longint      lo;
        r.result    = value;
        r.carry     = cin;
        r.saturated = 1'b0;
        w           = 32'(width);
        v           = longint'($signed(value));
        case (cmd)
            CMD_IMM_SHIFT: begin
                if (amount[4:0] != 5'd0) begin
                    r = shift_by(kind, value, 32'(amount[4:0]));
                end else if (kind == KIND_ROR) begin
                    // RRX: carry enters at the top
                    r.result = {cin, value[W-1:1]};
                    r.carry  = value[0];
                end else if (kind != KIND_LSL) begin
                    r = shift_by(kind, value, W);
                end
            end
            CMD_REG_SHIFT: begin
                if (amount != 8'd0) r = shift_by(kind, value, 32'(amount));
            end
            CMD_SSAT: begin
                if (w < 1) w = 1;
                if (w > W) w = W;
                hi = (longint'(1) << (w - 1)) - 1;
                lo = -hi - 1;
                if (v > hi) begin
                    v           = hi;
                    r.saturated = 1'b1;
                end else if (v < lo) begin
                    v           = lo;
                    r.saturated = 1'b1;
                end
                r.result = v[W-1:0];
            end
            default: begin
                if (w > W) w = W;
                hi = (w == 0) ? 64'sd0 : (longint'(1) << w) - 1;
                if (v < 0) begin
                    r.result    = '0;
                    r.saturated = 1'b1;
                end else if (v > hi) begin
                    r.result    = hi[W-1:0];
                    r.saturated = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_shift_sat want;
        if (i_rst_n) begin
            // retire first, so a beat entering on this edge is never matched at once
            if (i_res_valid && !i_res_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: result %h", i_result);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_result !== want.result) begin
                        $error("result: expected %h, actual %h", want.result, i_result);
                        mismatch_count++;
                    end
                    if (i_carry_out !== want.carry) begin
                        $error("carry_out: expected %b, actual %b", want.carry, i_carry_out);
                        mismatch_count++;
                    end
                    if (i_saturated !== want.saturated) begin
                        $error("saturated: expected %b, actual %b", want.saturated,
                               i_saturated);
                        mismatch_count++;
                    end
                end
            end
            if (i_cmd_valid && !i_cmd_stall)
                pending_results.push_back(predict_shift_sat(i_command, i_value, i_shift_kind,
                                                            i_shift_amount, i_carry_in,
                                                            i_sat_width));
        end
        o_mismatch_count <= mismatch_count;
        o_outstanding    <= pending_results.size();
    end

endmodule

// ----- tb/sv/shift_carry_and_saturate_unit_tb.sv -----
// Testbench top of the shift, carry and saturate unit: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module shift_carry_and_saturate_unit_tb
    import scsu_pkg::*;
();

    localparam int DATA_BITS      = 32;
    localparam int RANDOM_BEATS   = 1925;
    // random beats in this window go without idling on either side
    localparam int QUIET_FROM     = 500;
    localparam int QUIET_TO       = 800;
    // receiver hold-off, placed inside the quiet window so the pipe fills
    localparam int HOLD_AT        = 650;
    localparam int HOLD_CYCLES    = 64;
    // sender drains the block completely at this random beat
    localparam int DRAIN_AT       = 1200;
    localparam int IDLE_PCT       = 34;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_command;
    logic [DATA_BITS-1:0] i_value;
    logic [1:0]           i_shift_kind;
    logic [7:0]           i_shift_amount;
    logic                 i_carry_in;
    logic [5:0]           i_sat_width;
    logic                 o_valid;
    logic                 i_stall;
    logic [DATA_BITS-1:0] o_result;
    logic                 o_carry_out;
    logic                 o_saturated;

    int mismatch_count;
    int outstanding;
    int beats_sent;
    int cycles_since_beat = 0;
    bit quiet;
    bit held_off;

    shift_carry_and_saturate_unit #(
        .DATA_BITS(DATA_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_shift_kind  (i_shift_kind),
        .i_shift_amount(i_shift_amount),
        .i_carry_in    (i_carry_in),
        .i_sat_width   (i_sat_width),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (o_result),
        .o_carry_out   (o_carry_out),
        .o_saturated   (o_saturated)
    );

    scsu_result_checker #(
        .DATA_BITS(DATA_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (i_valid),
        .i_cmd_stall     (o_stall),
        .i_command       (i_command),
        .i_value         (i_value),
        .i_shift_kind    (i_shift_kind),
        .i_shift_amount  (i_shift_amount),
        .i_carry_in      (i_carry_in),
        .i_sat_width     (i_sat_width),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_result        (o_result),
        .i_carry_out     (o_carry_out),
        .i_saturated     (o_saturated),
        .o_mismatch_count(mismatch_count),
        .o_outstanding   (outstanding)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Offer one beat: idle at random first, then hold the payload until accepted.
    // Valid is never lowered on account of a stall.
    task automatic offer_beat(input logic [1:0] cmd, input logic [DATA_BITS-1:0] value,
                              input logic [1:0] kind, input logic [7:0] amount,
                              input logic cin, input logic [5:0] width);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_value        <= value;
        i_shift_kind   <= kind;
        i_shift_amount <= amount;
        i_carry_in     <= cin;
        i_sat_width    <= width;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_block();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Operand mix: small magnitudes, powers of two either side, extremes, noise.
    function automatic logic [DATA_BITS-1:0] pick_operand();
        logic [DATA_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 300);
            1: v = -$urandom_range(1, 300);
            2: begin
                v = (32'h1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) v = -v;
            end
            3: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Receiver: stall at random, once hold off for a long stretch so the
    // pipeline backs up into o_stall.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_off && beats_sent >= HOLD_AT) begin
                held_off = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: give up when neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            cycles_since_beat <= 0;
        end else if (cycles_since_beat >= WATCHDOG_LIMIT) begin
            $display("** shift_carry_and_saturate_unit: FAILED **");
            $finish;
        end else begin
            cycles_since_beat <= cycles_since_beat + 1;
        end
    end

    initial begin
        logic [1:0] cmd;
        logic [7:0] amount;
        logic [5:0] width;
        beats_sent        = 0;
        quiet             = 1'b0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_command      <= CMD_IMM_SHIFT;
        i_value        <= '0;
        i_shift_kind   <= KIND_LSL;
        i_shift_amount <= '0;
        i_carry_in     <= 1'b0;
        i_sat_width    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners. Immediate form with a zero imm5: LSL passes value and
        // carry, LSR/ASR shift by the full width, ROR becomes RRX. Bit 5 set in the
        // amount checks that only the low five bits count.
        offer_beat(CMD_IMM_SHIFT, 32'h8000_0001, KIND_LSL, 8'h00, 1'b1, 6'd0);
        offer_beat(CMD_IMM_SHIFT, 32'h8000_0000, KIND_LSR, 8'h20, 1'b0, 6'd0);
        offer_beat(CMD_IMM_SHIFT, 32'h8000_0000, KIND_ASR, 8'h00, 1'b0, 6'd0);
        offer_beat(CMD_IMM_SHIFT, 32'h0000_0001, KIND_ROR, 8'h00, 1'b1, 6'd0);
        offer_beat(CMD_IMM_SHIFT, 32'hFFFF_FFFE, KIND_ROR, 8'hE0, 1'b0, 6'd0);
        offer_beat(CMD_IMM_SHIFT, 32'hFFFF_FFFF, KIND_LSL, 8'h1F, 1'b0, 6'd0);
        offer_beat(CMD_IMM_SHIFT, 32'h8000_0000, KIND_ROR, 8'hFF, 1'b1, 6'd0);
        // Register amounts: zero passes through, the width and beyond clear or
        // sign-fill, rotation wraps modulo the width.
        offer_beat(CMD_REG_SHIFT, 32'h1234_5678, KIND_ASR, 8'd0,   1'b1, 6'd0);
        offer_beat(CMD_REG_SHIFT, 32'h0000_0001, KIND_LSL, 8'd32,  1'b0, 6'd0);
        offer_beat(CMD_REG_SHIFT, 32'hFFFF_FFFF, KIND_LSL, 8'd33,  1'b1, 6'd0);
        offer_beat(CMD_REG_SHIFT, 32'h8000_0000, KIND_LSR, 8'd32,  1'b0, 6'd0);
        offer_beat(CMD_REG_SHIFT, 32'hFFFF_FFFF, KIND_LSR, 8'd255, 1'b1, 6'd0);
        offer_beat(CMD_REG_SHIFT, 32'h8000_0000, KIND_ASR, 8'd255, 1'b0, 6'd0);
        offer_beat(CMD_REG_SHIFT, 32'h7FFF_FFFF, KIND_ASR, 8'd40,  1'b1, 6'd0);
        offer_beat(CMD_REG_SHIFT, 32'h8000_0001, KIND_ROR, 8'd32,  1'b0, 6'd0);
        offer_beat(CMD_REG_SHIFT, 32'h1234_5678, KIND_ROR, 8'd255, 1'b0, 6'd0);
        // Signed saturation: width zero acts as one, widths above 32 act as 32.
        offer_beat(CMD_SSAT, 32'h7FFF_FFFF, KIND_LSL, 8'd0, 1'b1, 6'd0);
        offer_beat(CMD_SSAT, 32'h8000_0000, KIND_LSL, 8'd0, 1'b0, 6'd1);
        offer_beat(CMD_SSAT, 32'h8000_0000, KIND_LSL, 8'd0, 1'b1, 6'd32);
        offer_beat(CMD_SSAT, 32'hFFFF_FFFF, KIND_LSL, 8'd0, 1'b0, 6'd63);
        offer_beat(CMD_SSAT, 32'h0000_007F, KIND_LSL, 8'd0, 1'b1, 6'd8);
        // Unsigned saturation: width zero clamps everything to zero, negatives to zero.
        offer_beat(CMD_USAT, 32'h0000_0000, KIND_LSL, 8'd0, 1'b1, 6'd0);
        offer_beat(CMD_USAT, 32'h0000_0001, KIND_LSL, 8'd0, 1'b0, 6'd0);
        offer_beat(CMD_USAT, 32'h8000_0000, KIND_LSL, 8'd0, 1'b1, 6'd31);
        offer_beat(CMD_USAT, 32'h7FFF_FFFF, KIND_LSL, 8'd0, 1'b0, 6'd63);
        drain_block();

        // Random beats, biased towards zero imm5, amounts near the width and
        // widths near their limits.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            quiet = (n >= QUIET_FROM) && (n < QUIET_TO);
            if (n == DRAIN_AT) drain_block();
            cmd = 2'($urandom_range(0, 3));
            if (cmd == CMD_REG_SHIFT && $urandom_range(0, 9) < 6)
                amount = 8'($urandom_range(0, 40));
            else if (cmd == CMD_IMM_SHIFT && $urandom_range(0, 4) == 0)
                amount = {3'($urandom_range(0, 7)), 5'd0};
            else
                amount = 8'($urandom_range(0, 255));
            width = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 33));
            offer_beat(cmd, pick_operand(), 2'($urandom_range(0, 3)), amount,
                       1'($urandom_range(0, 1)), width);
        end
        quiet = 1'b0;

        // Let the pipe empty, then keep watching for stray beats before the verdict.
        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("** shift_carry_and_saturate_unit: PASSED **");
        end else begin
            $display("** shift_carry_and_saturate_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- shift_carry_and_saturate_unit.f -----
rtl/scsu_pkg.sv
rtl/scsu_decode.sv
rtl/scsu_exec.sv
rtl/scsu_final.sv
rtl/shift_carry_and_saturate_unit.sv
tb/sv/scsu_result_checker.sv
tb/sv/shift_carry_and_saturate_unit_tb.sv
